### rtl/core/ewsm_pkg.sv
package ewsm_pkg;

    // Snapshot ring depth, in sample ticks.
    localparam int WINDOW = 100;
    localparam int PTR_W  = $clog2(WINDOW);

    // Field and register widths.
    localparam int POS_W   = 32;
    localparam int SPEED_W = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 1'd1;

    // Input operation codes.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Full-scale speed and the serial divider geometry.
    localparam int FULL_SCALE = 100;
    localparam int DVD_W      = 23;   // 100 * 65535 fits in 23 bits
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int QUO_W      = 7;    // quotient stays below 100

endpackage

### rtl/core/ewsm_if.sv
// Input channel: one beat is an encoder edge event or a sample tick.
interface ewsm_in_if;
    logic valid;
    logic ready;
    logic op;
    logic dir_level;

    modport source (output valid, output op, output dir_level, input ready);
    modport sink   (input valid, input op, input dir_level, output ready);
endinterface

// Output channel: one beat per sample tick.
interface ewsm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ewsm_pkg::POS_W-1:0]   rate;
    logic signed [ewsm_pkg::SPEED_W-1:0] speed;

    modport source (output valid, output rate, output speed, input ready);
    modport sink   (input valid, input rate, input speed, output ready);
endinterface

### rtl/core/encoder_window_speed_meter.sv
// Encoder speed meter. Edge beats (op = 0) step a wrapping 32-bit position up
// or down by the B-phase level; they are taken in any cycle in which the block
// is idle and give no output. A tick beat (op = 1) reads the position stored
// WINDOW ticks earlier from a single-port snapshot memory (zero until the ring
// has been filled once, tracked by a fill flag, so no clearing pass runs after
// reset), rewrites that slot, and returns the rate and a -100..100 speed.
// A tick whose rate lands in the deadband or in saturation goes from the read,
// rate and band states straight to the output register; one in a scaling band
// first passes through the 23-step restoring divider that works out
// 100 * (|rate| - speed_min) / (speed_max - speed_min) and a sign step. The
// input is not ready while a tick is in work, nor while a finished result
// waits for a full output register to drain. Configuration writes are taken
// at any time but must only be made while the block is idle.
module encoder_window_speed_meter (
    input  logic                               clk,
    input  logic                               rst_n,
    ewsm_in_if.sink                            in_ch,
    ewsm_out_if.source                         out_ch,
    input  logic                               cfg_wr_en,
    input  logic [ewsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ewsm_pkg::CFG_W-1:0]         cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DIFF  = 3'd2;
    localparam logic [2:0] ST_CLASS = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SIGN  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    localparam int PW = ewsm_pkg::POS_W;
    localparam int SW = ewsm_pkg::SPEED_W;
    localparam int CW = ewsm_pkg::CFG_W;
    localparam int DW = ewsm_pkg::DVD_W;

    logic [2:0]                       state_reg, state_next;
    logic [PW-1:0]                    pos_reg;
    logic [ewsm_pkg::PTR_W-1:0]       ptr_reg;
    logic                             filled_reg;
    logic [CW-1:0]                    min_reg, max_reg;
    logic [PW-1:0]                    mem [ewsm_pkg::WINDOW];
    logic [PW-1:0]                    rd_data_reg;
    logic [PW-1:0]                    rate_reg;
    logic [CW-1:0]                    den_reg;
    logic [CW-1:0]                    rem_reg;
    logic [DW-1:0]                    quo_reg;
    logic [ewsm_pkg::CNT_W-1:0]       cnt_reg;
    logic                             neg_reg;
    logic [SW-1:0]                    spd_reg;
    logic                             out_valid_reg;
    logic [PW-1:0]                    out_rate_reg;
    logic [SW-1:0]                    out_speed_reg;

    logic                             in_fire;
    logic                             out_free;
    logic signed [PW:0]               r_ext, lo_ext, hi_ext;
    logic                             below_neg_hi, below_neg_lo, below_lo, below_hi;
    logic [PW:0]                      mag_neg, mag_pos;
    logic [CW-1:0]                    num;
    logic [DW-1:0]                    dividend;
    logic [CW:0]                      trial;
    logic [CW+1:0]                    trial_sub;
    logic                             trial_ge;
    logic [SW-1:0]                    quo_ext;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.rate  = out_rate_reg;
    assign out_ch.speed = out_speed_reg;

    // Band classification of the rate against the signed thresholds.
    assign r_ext  = {rate_reg[PW-1], rate_reg};
    assign lo_ext = {{(PW+1-CW){1'b0}}, min_reg};
    assign hi_ext = {{(PW+1-CW){1'b0}}, max_reg};
    assign below_neg_hi = r_ext < -hi_ext;
    assign below_neg_lo = r_ext < -lo_ext;
    assign below_lo     = r_ext < lo_ext;
    assign below_hi     = r_ext < hi_ext;
    assign mag_neg  = $unsigned(-r_ext - lo_ext);
    assign mag_pos  = $unsigned(r_ext - lo_ext);
    assign num      = below_neg_lo ? mag_neg[CW-1:0] : mag_pos[CW-1:0];
    assign dividend = {{(DW-CW){1'b0}}, num} * DW'(ewsm_pkg::FULL_SCALE);

    // One restoring division step.
    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = {1'b0, trial} - {2'b00, den_reg};
    assign trial_ge  = !trial_sub[CW+1];
    assign quo_ext   = {1'b0, quo_reg[ewsm_pkg::QUO_W-1:0]};

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_ch.op == ewsm_pkg::OP_TICK)
                    state_next = ST_READ;
            end
            ST_READ:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_CLASS;
            ST_CLASS:
            begin
                if (!below_neg_hi && below_neg_lo)
                    state_next = ST_DIV;
                else if (!below_lo && below_hi)
                    state_next = ST_DIV;
                else
                    state_next = ST_FIN;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_SIGN;
            end
            ST_SIGN:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, position, ring pointer, fill flag, limits and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            filled_reg    <= 1'b0;
            min_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && in_ch.op == ewsm_pkg::OP_EDGE)
                pos_reg <= in_ch.dir_level ? pos_reg + PW'(1) : pos_reg - PW'(1);
            if (state_reg == ST_DIFF)
            begin
                if (ptr_reg == ewsm_pkg::PTR_W'(ewsm_pkg::WINDOW - 1))
                begin
                    ptr_reg    <= '0;
                    filled_reg <= 1'b1;
                end
                else
                    ptr_reg <= ptr_reg + ewsm_pkg::PTR_W'(1);
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ewsm_pkg::REG_SPEED_MIN: min_reg <= cfg_data;
                    ewsm_pkg::REG_SPEED_MAX: max_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Snapshot memory: registered read, then rewrite of the same slot.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            rd_data_reg <= mem[ptr_reg];
        if (state_reg == ST_DIFF)
            mem[ptr_reg] <= pos_reg;
    end

    // Datapath: rate, band results, the serial divider and the output registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIFF)
            rate_reg <= pos_reg - (filled_reg ? rd_data_reg : '0);
        if (state_reg == ST_CLASS)
        begin
            neg_reg <= below_neg_lo;
            den_reg <= max_reg - min_reg;
            rem_reg <= '0;
            quo_reg <= dividend;
            cnt_reg <= ewsm_pkg::CNT_W'(DW - 1);
            if (below_neg_hi)
                spd_reg <= SW'(-ewsm_pkg::FULL_SCALE);
            else if (below_neg_lo)
                spd_reg <= '0;
            else if (below_lo)
                spd_reg <= '0;
            else if (below_hi)
                spd_reg <= '0;
            else
                spd_reg <= SW'(ewsm_pkg::FULL_SCALE);
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
            quo_reg <= {quo_reg[DW-2:0], trial_ge};
            cnt_reg <= cnt_reg - ewsm_pkg::CNT_W'(1);
        end
        if (state_reg == ST_SIGN)
            spd_reg <= neg_reg ? -quo_ext : quo_ext;
        if (state_reg == ST_FIN && out_free)
        begin
            out_rate_reg  <= rate_reg;
            out_speed_reg <= spd_reg;
        end
    end

endmodule

### rtl/core/ewsm_checker.sv
// Port-level checks for the encoder speed meter.
module ewsm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               in_op,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [ewsm_pkg::POS_W-1:0]         out_rate,
    input logic [ewsm_pkg::SPEED_W-1:0]       out_speed
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rate) && $stable(out_speed))
        else $error("output beat changed while stalled");

    // A tick occupies the block for at least the following cycle.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op == ewsm_pkg::OP_TICK |=> !in_ready)
        else $error("input ready right after a tick");

    // The speed stays within full scale.
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(out_speed) >= -8'sd100 && $signed(out_speed) <= 8'sd100)
        else $error("speed out of range");

    // A negative speed only comes from a negative rate.
    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_speed[ewsm_pkg::SPEED_W-1] |-> out_rate[ewsm_pkg::POS_W-1])
        else $error("negative speed with non-negative rate");

endmodule

bind encoder_window_speed_meter ewsm_checker u_ewsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rate  (out_ch.rate),
    .out_speed (out_ch.speed)
);

### tb/tb_encoder_window_speed_meter.sv
`timescale 1ns / 100ps

module tb_encoder_window_speed_meter;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 40;

    typedef struct packed {
        logic op;
        logic dir_level;
    } enc_beat_t;

    typedef struct packed {
        logic signed [ewsm_pkg::POS_W-1:0]   rate;
        logic signed [ewsm_pkg::SPEED_W-1:0] speed;
    } speed_sample_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                           cfg_wr_en;
    logic [ewsm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ewsm_pkg::CFG_W-1:0]     cfg_data;

    ewsm_in_if  in_ch();
    ewsm_out_if out_ch();

    encoder_window_speed_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Pending stimulus, expected results and bookkeeping.
    enc_beat_t     pending_beats[$];
    speed_sample_t expected_samples[$];
    enc_beat_t     next_beat;
    speed_sample_t seen_sample;
    int            beats_queued = 0;
    int            beats_taken = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            sender_idle_pct = 0;
    int            sink_stall_pct = 0;

    // Shadow copy of the meter state.
    logic [ewsm_pkg::POS_W-1:0] position_count = '0;
    logic [ewsm_pkg::POS_W-1:0] snapshots[ewsm_pkg::WINDOW];
    int                         slot_ptr = 0;
    logic [ewsm_pkg::CFG_W-1:0] band_lo = '0;
    logic [ewsm_pkg::CFG_W-1:0] band_hi = '0;

    initial
    begin
        foreach (snapshots[i])
            snapshots[i] = '0;
    end

    // Steps the shadow state by one accepted beat and records the result of a tick.
    function automatic void track_beat(input enc_beat_t beat);
        logic [ewsm_pkg::POS_W-1:0] diff;
        longint                     r;
        longint                     lo;
        longint                     hi;
        int                         pct;
        speed_sample_t              sample;
        if (beat.op == ewsm_pkg::OP_EDGE)
        begin
            if (beat.dir_level)
                position_count = position_count + 1;
            else
                position_count = position_count - 1;
            return;
        end
        diff = position_count - snapshots[slot_ptr];
        snapshots[slot_ptr] = position_count;
        slot_ptr = (slot_ptr == ewsm_pkg::WINDOW - 1) ? 0 : slot_ptr + 1;
        r  = longint'($signed(diff));
        lo = longint'(band_lo);
        hi = longint'(band_hi);
        // Negative saturation, negative band, deadband, positive band, positive saturation, in priority order.
        if (r < -hi)
            pct = -ewsm_pkg::FULL_SCALE;
        else if (r < -lo)
            pct = -int'((100 * (-r - lo)) / (hi - lo));
        else if (r < lo)
            pct = 0;
        else if (r < hi)
            pct = int'((100 * (r - lo)) / (hi - lo));
        else
            pct = ewsm_pkg::FULL_SCALE;
        sample.rate  = diff;
        sample.speed = pct[ewsm_pkg::SPEED_W-1:0];
        expected_samples.push_back(sample);
    endfunction

    // Input driver: holds a beat until it is taken, idles at random between beats.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.op        <= ewsm_pkg::OP_EDGE;
            in_ch.dir_level <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                track_beat('{op: in_ch.op, dir_level: in_ch.dir_level});
                beats_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_beat = pending_beats.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.op        <= next_beat.op;
                    in_ch.dir_level <= next_beat.dir_level;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output backpressure.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Output monitor: each result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual rate %0d speed %0d",
                         $time, out_ch.rate, out_ch.speed);
                mismatches++;
            end
            else
            begin
                seen_sample = expected_samples.pop_front();
                if (out_ch.rate !== seen_sample.rate)
                begin
                    $display("%0t: rate mismatch, expected %0d, actual %0d",
                             $time, seen_sample.rate, out_ch.rate);
                    mismatches++;
                end
                if (out_ch.speed !== seen_sample.speed)
                begin
                    $display("%0t: speed mismatch, expected %0d, actual %0d",
                             $time, seen_sample.speed, out_ch.speed);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void set_idle(input idle_mode_t mode);
        sender_idle_pct = (mode == IDLE_SENDER) ? 78 : (mode == IDLE_BOTH) ? 19 : 0;
        sink_stall_pct  = (mode == IDLE_SINK)   ? 78 : (mode == IDLE_BOTH) ? 19 : 0;
    endfunction

    function automatic void queue_beat(input logic op, input logic dir_level);
        pending_beats.push_back('{op: op, dir_level: dir_level});
        beats_queued++;
    endfunction

    // Waits until every beat is taken and every result is back, then lets a
    // trailing edge beat or tick finish inside the block.
    task automatic settle_block();
        while (beats_taken != beats_queued || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ewsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ewsm_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == ewsm_pkg::REG_SPEED_MIN)
            band_lo = value;
        else
            band_hi = value;
    endtask

    task automatic apply_limits(input logic [ewsm_pkg::CFG_W-1:0] lo,
                                input logic [ewsm_pkg::CFG_W-1:0] hi);
        settle_block();
        write_reg(ewsm_pkg::REG_SPEED_MIN, lo);
        write_reg(ewsm_pkg::REG_SPEED_MAX, hi);
    endtask

    // Bursts of edges with a drifting direction, each closed by a tick, plus
    // some fully random beats as noise.
    task automatic queue_traffic(input int count);
        int  made;
        int  burst;
        logic drift;
        made  = 0;
        drift = 1'($urandom_range(1));
        while (made < count)
        begin
            if ($urandom_range(9) == 0)
                drift = ~drift;
            if ($urandom_range(9) == 0)
            begin
                queue_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end
            else
            begin
                burst = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 12);
                repeat (burst)
                begin
                    queue_beat(ewsm_pkg::OP_EDGE, ($urandom_range(99) < 80) ? drift : ~drift);
                    made++;
                end
                queue_beat(ewsm_pkg::OP_TICK, 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    initial
    begin
        int unsigned lo_set[9] = '{0, 3, 0, 65535, 20, 65535, 0, 10, 1};
        int unsigned hi_set[9] = '{0, 30, 65535, 65535, 5, 0, 1, 200, 2};
        cfg_wr_en       <= 1'b0;
        cfg_index       <= ewsm_pkg::REG_SPEED_MIN;
        cfg_data        <= '0;
        set_idle(IDLE_NONE);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Both limits zero: a zero rate saturates up, any negative rate down.
        apply_limits(16'd0, 16'd0);
        queue_beat(ewsm_pkg::OP_TICK, 1'b0);
        queue_beat(ewsm_pkg::OP_EDGE, 1'b0);
        queue_beat(ewsm_pkg::OP_TICK, 1'b1);

        // Deadband, negative band, negative saturation, positive band, positive saturation.
        apply_limits(16'd1, 16'd4);
        queue_beat(ewsm_pkg::OP_TICK, 1'b0);
        queue_beat(ewsm_pkg::OP_EDGE, 1'b0);
        queue_beat(ewsm_pkg::OP_TICK, 1'b0);
        repeat (3) queue_beat(ewsm_pkg::OP_EDGE, 1'b0);
        queue_beat(ewsm_pkg::OP_TICK, 1'b1);
        repeat (8) queue_beat(ewsm_pkg::OP_EDGE, 1'b1);
        queue_beat(ewsm_pkg::OP_TICK, 1'b0);
        queue_beat(ewsm_pkg::OP_EDGE, 1'b1);
        queue_beat(ewsm_pkg::OP_TICK, 1'b1);

        // Random traffic over a range of limits, including max not above min.
        for (int p = 0; p < 9; p++)
        begin
            apply_limits(lo_set[p][ewsm_pkg::CFG_W-1:0], hi_set[p][ewsm_pkg::CFG_W-1:0]);
            set_idle(idle_mode_t'(p % 4));
            queue_traffic(160);
        end

        settle_block();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
